### hdl/lobm_pkg.sv
// lobm_pkg: shared types and constants of the limit order book matcher.
// Used by all hdl modules and the checker.
package lobm_pkg;

	localparam int ORDER_SLOTS_DEF = 32;

	localparam logic FUNC_SUBMIT = 1'b0;
	localparam logic FUNC_CANCEL = 1'b1;

	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	localparam logic [2:0] ST_RESTED   = 3'd0;
	localparam logic [2:0] ST_FILLED   = 3'd1;
	localparam logic [2:0] ST_DROPPED  = 3'd2;
	localparam logic [2:0] ST_CANCELED = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;

	typedef struct packed {
		logic        func;
		logic [31:0] order_id;
		logic        is_buy;
		logic [31:0] limit_price;
		logic [31:0] quantity;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] resting_id;
		logic [31:0] fill_qty;
		logic [31:0] trade_price;
		logic [2:0]  status;
		logic [31:0] left_qty;
		logic [5:0]  live_orders;
		logic [63:0] executions;
		logic        last;
	} rsp_t;

	typedef enum logic {OP_SUBMIT, OP_CANCEL} op_t;

	// classified request handed from the front queue to the engine
	typedef struct packed {
		op_t         op;
		logic        zero_qty;
		logic [31:0] order_id;
		logic        is_buy;
		logic [31:0] limit_price;
		logic [31:0] quantity;
	} cmd_t;

	// one resting order
	typedef struct packed {
		logic [31:0] order_id;
		logic        buy;
		logic [31:0] price;
		logic [31:0] qty;
		logic [31:0] age;
	} slot_t;

	typedef struct packed {
		logic [31:0] resting_id;
		logic [31:0] qty;
		logic [31:0] price;
	} trade_t;

	// engine -> report unit
	typedef struct packed {
		logic        trade_en;
		trade_t      trade;
		logic        done;
		logic [2:0]  status;
		logic [31:0] left_qty;
		logic [5:0]  live;
		logic [63:0] execs;
	} eng_rep_t;

	typedef enum logic [1:0] {ENG_IDLE, ENG_SCAN, ENG_ACT, ENG_FINISH} eng_state_t;
	typedef enum logic [1:0] {REP_IDLE, REP_FETCH, REP_EMIT, REP_LAST} rep_state_t;

endpackage

### hdl/lobm_chan_if.sv
// lobm_chan_if: valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from lobm_pkg.
interface lobm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/lobm_front.sv
// lobm_front: accepts requests, classifies them, queues two for the engine.
// Depends on lobm_pkg and lobm_chan_if.
module lobm_front
	import lobm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	lobm_chan_if.sink            req,
	output logic                 cmd_valid,
	output cmd_t                 cmd,
	input  logic                 cmd_pop
);
	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cls;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_comb begin
		cls.op          = (req.data.func == FUNC_CANCEL) ? OP_CANCEL : OP_SUBMIT;
		cls.zero_qty    = (req.data.quantity == 32'd0);
		cls.order_id    = req.data.order_id;
		cls.is_buy      = req.data.is_buy;
		cls.limit_price = req.data.limit_price;
		cls.quantity    = req.data.quantity;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

### hdl/lobm_engine.sv
// lobm_engine: order table and matching sequencer (scan, fill, rest, cancel).
// Depends on lobm_pkg; feeds lobm_report.
module lobm_engine
	import lobm_pkg::*;
#(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  cmd_t     cmd,
	output logic     cmd_pop,
	input  logic     rep_busy,
	output eng_rep_t eng
);
	localparam int IW = $clog2(ORDER_SLOTS);
	localparam int CW = $clog2(ORDER_SLOTS + 1);

	eng_state_t state_q, state_d;

	slot_t mem [ORDER_SLOTS];
	logic                   we;
	logic [IW-1:0]          waddr;
	slot_t                  wdata;

	logic [ORDER_SLOTS-1:0] valid_q;
	op_t                    op_q;
	logic [31:0]            id_q;
	logic                   buy_q;
	logic [31:0]            limit_q;
	logic [31:0]            rem_q;
	logic [31:0]            stamp_q;
	logic [63:0]            total_q;
	logic [5:0]             live_q;
	logic [CW-1:0]          ntr_q;

	logic [CW-1:0]          scan_idx_q;
	logic                   rd_vld_s1;
	logic [IW-1:0]          rd_idx_s1;
	slot_t                  rd_s1;

	logic                   best_found_q;
	logic [IW-1:0]          best_idx_q;
	slot_t                  best_q;
	logic [31:0]            best_age_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_idx_q;

	logic                   issue;
	logic                   scan_end;
	logic                   accept;
	logic [31:0]            age;
	logic                   crosses;
	logic                   cand;
	logic                   better;
	logic [31:0]            fill;
	logic [31:0]            new_qty;
	logic [31:0]            rem_next;
	logic                   more;

	assign issue    = (state_q == ENG_SCAN) && (scan_idx_q < CW'(ORDER_SLOTS));
	assign scan_end = rd_vld_s1 && (rd_idx_s1 == IW'(ORDER_SLOTS - 1));
	assign accept   = cmd_pop;

	// evaluate one table entry per cycle
	always_comb begin
		age     = stamp_q - rd_s1.age;
		crosses = buy_q ? (limit_q >= rd_s1.price) : (limit_q <= rd_s1.price);
		if (op_q == OP_CANCEL) begin
			cand   = valid_q[rd_idx_s1] && (rd_s1.order_id == id_q);
			better = !best_found_q || (age < best_age_q);
		end else begin
			cand   = valid_q[rd_idx_s1] && (rd_s1.buy != buy_q) && crosses;
			better = !best_found_q
				|| (buy_q ? (rd_s1.price < best_q.price) : (rd_s1.price > best_q.price))
				|| ((rd_s1.price == best_q.price) && (age > best_age_q));
		end
	end

	always_comb begin
		fill     = (rem_q < best_q.qty) ? rem_q : best_q.qty;
		new_qty  = best_q.qty - fill;
		rem_next = rem_q - fill;
		more     = (rem_next != 32'd0) && (ntr_q != CW'(ORDER_SLOTS - 1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ENG_IDLE: begin
				if (accept) begin
					state_d = (cmd.op == OP_SUBMIT && cmd.zero_qty) ? ENG_FINISH : ENG_SCAN;
				end
			end
			ENG_SCAN: begin
				if (scan_end) begin
					state_d = ENG_ACT;
				end
			end
			ENG_ACT: begin
				if (op_q == OP_SUBMIT && best_found_q && more) begin
					state_d = ENG_SCAN;
				end else begin
					state_d = ENG_FINISH;
				end
			end
			ENG_FINISH: state_d = ENG_IDLE;
			default:    state_d = ENG_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop        = (state_q == ENG_IDLE) && cmd_valid && !rep_busy;
		we             = 1'b0;
		waddr          = best_idx_q;
		wdata          = best_q;
		wdata.qty      = new_qty;
		eng.trade_en   = 1'b0;
		eng.trade.resting_id = best_q.order_id;
		eng.trade.qty  = fill;
		eng.trade.price = best_q.price;
		eng.done       = 1'b0;
		eng.status     = ST_FILLED;
		eng.left_qty   = 32'd0;
		eng.live       = live_q;
		eng.execs      = total_q;
		case (state_q)
			ENG_ACT: begin
				if (op_q == OP_SUBMIT && best_found_q) begin
					we           = 1'b1;
					eng.trade_en = 1'b1;
				end
			end
			ENG_FINISH: begin
				eng.done = 1'b1;
				if (op_q == OP_CANCEL) begin
					eng.status = best_found_q ? ST_CANCELED : ST_UNKNOWN;
				end else begin
					eng.left_qty = rem_q;
					if (rem_q == 32'd0) begin
						eng.status = ST_FILLED;
					end else if (free_found_q) begin
						eng.status     = ST_RESTED;
						we             = 1'b1;
						waddr          = free_idx_q;
						wdata.order_id = id_q;
						wdata.buy      = buy_q;
						wdata.price    = limit_q;
						wdata.qty      = rem_q;
						wdata.age      = stamp_q - 32'd1;
					end else begin
						eng.status = ST_DROPPED;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[scan_idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= cmd.op;
			id_q    <= cmd.order_id;
			buy_q   <= cmd.is_buy;
			limit_q <= cmd.limit_price;
			rem_q   <= cmd.quantity;
		end else if (state_q == ENG_ACT && op_q == OP_SUBMIT && best_found_q) begin
			rem_q <= rem_next;
		end
		if (rd_vld_s1 && cand && better) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_s1;
			best_age_q <= age;
		end
		rd_idx_s1 <= scan_idx_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ENG_IDLE;
			valid_q      <= '0;
			stamp_q      <= 32'd0;
			total_q      <= 64'd0;
			live_q       <= 6'd0;
			ntr_q        <= '0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (issue) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (rd_vld_s1) begin
				if (cand && better) begin
					best_found_q <= 1'b1;
				end
				if (!valid_q[rd_idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= rd_idx_s1;
				end
			end
			case (state_q)
				ENG_IDLE: begin
					if (accept) begin
						ntr_q        <= '0;
						scan_idx_q   <= '0;
						best_found_q <= 1'b0;
						free_found_q <= 1'b0;
						if (cmd.op == OP_SUBMIT) begin
							stamp_q <= stamp_q + 32'd1;
						end
					end
				end
				ENG_ACT: begin
					if (op_q == OP_CANCEL) begin
						if (best_found_q) begin
							valid_q[best_idx_q] <= 1'b0;
							live_q              <= live_q - 6'd1;
						end
					end else if (best_found_q) begin
						total_q <= total_q + 64'd1;
						ntr_q   <= ntr_q + CW'(1);
						if (new_qty == 32'd0) begin
							valid_q[best_idx_q] <= 1'b0;
							live_q              <= live_q - 6'd1;
							if (!free_found_q || best_idx_q < free_idx_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= best_idx_q;
							end
						end
						if (more) begin
							// rescan; free slot is recomputed by the scan
							scan_idx_q   <= '0;
							best_found_q <= 1'b0;
							free_found_q <= 1'b0;
						end
					end
				end
				ENG_FINISH: begin
					if (op_q == OP_SUBMIT && rem_q != 32'd0 && free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
						live_q              <= live_q + 6'd1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### hdl/lobm_report.sv
// lobm_report: buffers the trades of one request, then plays them out with the completion.
// Depends on lobm_pkg and lobm_chan_if; fed by lobm_engine.
module lobm_report
	import lobm_pkg::*;
#(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  eng_rep_t   eng,
	output logic       busy,
	lobm_chan_if.source rsp
);
	localparam int IW = $clog2(ORDER_SLOTS);
	localparam int CW = $clog2(ORDER_SLOTS + 1);

	rep_state_t state_q, state_d;

	trade_t        tbuf [ORDER_SLOTS];
	trade_t        rdata_q;
	logic [CW-1:0] wr_ptr_q;
	logic [CW-1:0] rd_ptr_q;
	logic [2:0]    status_q;
	logic [31:0]   left_q;
	logic          out_valid_q;
	rsp_t          out_q;
	logic          free;
	logic          load_trade;
	logic          load_last;

	assign free      = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			REP_IDLE: begin
				if (eng.done) begin
					state_d = (wr_ptr_q != '0) ? REP_FETCH : REP_LAST;
				end
			end
			REP_FETCH: state_d = REP_EMIT;
			REP_EMIT: begin
				if (free) begin
					state_d = (rd_ptr_q + CW'(1) == wr_ptr_q) ? REP_LAST : REP_FETCH;
				end
			end
			REP_LAST: begin
				if (free) begin
					state_d = REP_IDLE;
				end
			end
			default: state_d = REP_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != REP_IDLE);
		load_trade = (state_q == REP_EMIT) && free;
		load_last  = (state_q == REP_LAST) && free;
	end

	always_ff @(posedge clk) begin
		if (eng.trade_en) begin
			tbuf[wr_ptr_q[IW-1:0]] <= eng.trade;
		end
		rdata_q <= tbuf[rd_ptr_q[IW-1:0]];
		if (eng.done) begin
			status_q <= eng.status;
			left_q   <= eng.left_qty;
		end
		if (load_trade || load_last) begin
			out_q.kind        <= load_last ? KIND_DONE : KIND_TRADE;
			out_q.resting_id  <= load_last ? 32'd0 : rdata_q.resting_id;
			out_q.fill_qty    <= load_last ? 32'd0 : rdata_q.qty;
			out_q.trade_price <= load_last ? 32'd0 : rdata_q.price;
			out_q.status      <= load_last ? status_q : ST_RESTED;
			out_q.left_qty    <= load_last ? left_q : 32'd0;
			out_q.live_orders <= eng.live;
			out_q.executions  <= eng.execs;
			out_q.last        <= load_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= REP_IDLE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (eng.trade_en) begin
				wr_ptr_q <= wr_ptr_q + CW'(1);
			end
			if (load_trade) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (load_last) begin
				wr_ptr_q <= '0;
				rd_ptr_q <= '0;
			end
			if (load_trade || load_last) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### hdl/limit_order_book_matcher.sv
// limit_order_book_matcher: top level of the price-time priority order book.
// Depends on lobm_pkg, lobm_chan_if, lobm_front, lobm_engine, lobm_report.
//
//  channel | dir | payload | handshake
//  --------+-----+---------+-------------------------------------------
//  req     | in  | req_t   | valid/ready, request taken when both high
//  rsp     | out | rsp_t   | valid/ready, result taken when both high
//
// Scanning: each table scan reads one slot per cycle, covering all ORDER_SLOTS slots.
// A submit runs one pass per fill, plus a last pass that finds no crossing order
// unless it fills up or hits the trade limit; a zero quantity skips scanning; a cancel
// runs one pass. Results then leave trade by trade, each fetched from the buffer and then
// emitted, with the completion last; the next request starts once that playout has finished.
// Reset clears the slot valid bits, counters and all control at once; no clearing pass.
// A stalled rsp holds the report unit; a two-entry queue takes requests meanwhile until full.
module limit_order_book_matcher
	import lobm_pkg::*;
#(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lobm_chan_if.sink   req,
	lobm_chan_if.source rsp
);
	logic     cmd_valid;
	cmd_t     cmd;
	logic     cmd_pop;
	logic     rep_busy;
	eng_rep_t eng;

	// front: accept and classify, two-deep request queue
	lobm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: order table, best-price/oldest scan, fills, rest and cancel
	lobm_engine #(.ORDER_SLOTS(ORDER_SLOTS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rep_busy  (rep_busy),
		.eng       (eng)
	);

	// trade reports carry end-of-request totals, so they are buffered and replayed
	lobm_report #(.ORDER_SLOTS(ORDER_SLOTS)) u_report (
		.clk    (clk),
		.arst_n (arst_n),
		.eng    (eng),
		.busy   (rep_busy),
		.rsp    (rsp)
	);
endmodule

### hdl/lobm_chk.sv
// lobm_chk: port-level checks of the order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_chk
	import lobm_pkg::*;
#(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.last == (rsp_data.kind == KIND_DONE)))
		else $error("last flag does not match completion report");

	a_trade: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.kind == KIND_TRADE |->
			rsp_data.fill_qty != 32'd0 && rsp_data.status == ST_RESTED)
		else $error("bad trade report");

	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.live_orders <= 6'(ORDER_SLOTS))
		else $error("live order count beyond table size");
endmodule

bind limit_order_book_matcher lobm_chk #(.ORDER_SLOTS(ORDER_SLOTS)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
